### rtl/core/horizon_level_strength_defines.svh
// ----------------------------------------------------------------------------
// Horizon leveling strength: assertion macros
// Shared property wrappers for the horizon leveling strength core.
// ----------------------------------------------------------------------------
`ifndef HORIZON_LEVEL_STRENGTH_DEFINES_SVH
`define HORIZON_LEVEL_STRENGTH_DEFINES_SVH

// same-cycle implication, reported by $error
`define HLS_ASSERT_IMPL(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reported by $error
`define HLS_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/hls_pkg.sv
// ----------------------------------------------------------------------------
// Horizon leveling strength: package
// Field types, register codes, arithmetic constants and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package hls_pkg;

  localparam int DEFL_W      = 9;
  localparam int ANGLE_W     = 12;
  localparam int EFFECT_W    = 8;
  localparam int SENS_W      = 8;
  localparam int STRENGTH_W  = 7;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  typedef logic [DEFL_W-1:0]         defl_t;
  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic [STRENGTH_W-1:0]     strength_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TILT_MODE   = 2'd0,
    CFG_TILT_EFFECT = 2'd1,
    CFG_LEVEL_SENS  = 2'd2
  } cfg_index_t;

  localparam logic MODE_SAFE   = 1'b0;
  localparam logic MODE_EXPERT = 1'b1;

  localparam logic [EFFECT_W-1:0]   TILT_EFFECT_RESET = 8'd75;
  localparam logic [SENS_W-1:0]     LEVEL_SENS_RESET  = 8'd75;
  localparam logic [EFFECT_W-1:0]   EXPERT_EFFECT_MAX = 8'd175;
  localparam logic [DEFL_W-1:0]     DEFL_FULL         = 9'd500;
  localparam logic [STRENGTH_W-1:0] STRENGTH_MAX      = 7'd100;

  // reciprocal constants: x/5 = x*205>>10, x/18 = x*3641>>16,
  // x/10 = x*3277>>15, x/100 = x*167773>>24 over the ranges used here
  localparam logic [7:0]  DIV5_RECIP   = 8'd205;
  localparam logic [11:0] DIV18_RECIP  = 12'd3641;
  localparam logic [11:0] DIV10_RECIP  = 12'd3277;
  localparam logic [17:0] DIV100_RECIP = 18'd167773;

  // pipelined saturating divider
  localparam int DIV_NUM_W  = 15;
  localparam int DIV_DEN_W  = 10;
  localparam int DIV_Q_W    = 7;
  localparam int DIV_STAGES = DIV_Q_W + 1;

  typedef struct packed {
    logic [13:0] m;
    logic [14:0] num1;
    logic        num1_neg;
  } hls_carry_t;

  typedef struct packed {
    logic zero;
    logic num1_neg;
    logic expert;
  } hls_side_t;

  function automatic logic [10:0] div100(input logic [16:0] x);
    logic [34:0] prod;
    prod = 35'(x) * 35'(DIV100_RECIP);
    return prod[34:24];
  endfunction

endpackage

`default_nettype wire

### rtl/core/hls_if.sv
// ----------------------------------------------------------------------------
// Horizon leveling strength: channel interfaces
// Valid/ready channels for samples in and strength results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface hls_sample_if import hls_pkg::*; ();
  logic   valid;
  logic   ready;
  defl_t  stick_deflection;
  angle_t roll_angle;
  angle_t pitch_angle;

  modport source(output valid, output stick_deflection, output roll_angle,
                 output pitch_angle, input ready);
  modport sink(input valid, input stick_deflection, input roll_angle,
               input pitch_angle, output ready);
endinterface

interface hls_strength_if import hls_pkg::*; ();
  logic      valid;
  logic      ready;
  strength_t level_strength;

  modport source(output valid, output level_strength, input ready);
  modport sink(input valid, input level_strength, output ready);
endinterface

`default_nettype wire

### rtl/core/hls_div.sv
// ----------------------------------------------------------------------------
// Horizon leveling strength: pipelined divider
// Unsigned restoring divider: an overflow check, then one quotient bit
// per stage, quotient saturated to all ones when it does not fit.
// ----------------------------------------------------------------------------
`default_nettype none

module hls_div import hls_pkg::*; (
  input  logic                  clk,
  input  logic [DIV_STAGES-1:0] adv,
  input  logic [DIV_NUM_W-1:0]  num,
  input  logic [DIV_DEN_W-1:0]  den,
  output logic [DIV_Q_W-1:0]    quot
);

  localparam int CMP_W = DIV_DEN_W + DIV_Q_W;

  logic [DIV_NUM_W-1:0] rem [DIV_STAGES];
  logic [DIV_DEN_W-1:0] dv  [DIV_STAGES];
  logic [DIV_Q_W-1:0]   q   [DIV_STAGES];
  logic                 ovf [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      rem[0] <= num;
      dv[0]  <= den;
      q[0]   <= '0;
      ovf[0] <= (num >> DIV_Q_W) >= {{(DIV_NUM_W-DIV_DEN_W){1'b0}}, den};
    end
  end

  for (genvar j = 1; j < DIV_STAGES; j++) begin : g_step
    localparam int BIT = DIV_Q_W - j;
    logic [CMP_W-1:0] shifted;
    logic             fits;
    logic [CMP_W-1:0] diff;

    always_comb begin
      shifted = CMP_W'(dv[j-1]) << BIT;
      fits    = CMP_W'(rem[j-1]) >= shifted;
      diff    = CMP_W'(rem[j-1]) - shifted;
    end

    always_ff @(posedge clk) begin
      if (adv[j]) begin
        rem[j] <= fits ? diff[DIV_NUM_W-1:0] : rem[j-1];
        dv[j]  <= dv[j-1];
        q[j]   <= q[j-1] | (DIV_Q_W'(fits) << BIT);
        ovf[j] <= ovf[j-1];
      end
    end
  end

  assign quot = ovf[DIV_STAGES-1] ? '1 : q[DIV_STAGES-1];

endmodule

`default_nettype wire

### rtl/core/horizon_level_strength.sv
// ----------------------------------------------------------------------------
// Horizon leveling strength
// Leveling strength 0..100 per sample from stick deflection and attitude,
// in safe or expert tilt mode.
//
//   channel   dir  handshake      payload
//   sample    in   valid/ready    stick_deflection, roll_angle, pitch_angle
//   result    out  valid/ready    level_strength
//   cfg       in   cfg_write      cfg_index, cfg_data
//
// One item enters per cycle unless stalled results fill every stage.
// The pipeline is the eight arithmetic stages plus the eight divider stages.
// Reset clears the stage valid bits and loads the register defaults.
// A stalled result holds only the occupied stages; empty stages keep filling.
// ----------------------------------------------------------------------------
`default_nettype none
`include "horizon_level_strength_defines.svh"

module horizon_level_strength import hls_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  hls_sample_if.sink             sample,
  hls_strength_if.source         result
);

  localparam int ST_DIV0  = 6;
  localparam int ST_PROD  = ST_DIV0 + DIV_STAGES;
  localparam int ST_OUT   = ST_PROD + 1;
  localparam int N_STAGES = ST_OUT + 1;

  logic                tilt_mode;
  logic [EFFECT_W-1:0] tilt_effect;
  logic [SENS_W-1:0]   level_sensitivity;

  always_ff @(posedge clk) begin
    if (rst) begin
      tilt_mode         <= MODE_SAFE;
      tilt_effect       <= TILT_EFFECT_RESET;
      level_sensitivity <= LEVEL_SENS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TILT_MODE:   tilt_mode <= cfg_data[0];
        CFG_TILT_EFFECT: tilt_effect <= cfg_data;
        CFG_LEVEL_SENS:  level_sensitivity <= cfg_data;
        default: ;
      endcase
    end
  end

  logic        expert;
  logic        effect_off;
  logic [7:0]  cut_span;
  logic [11:0] cutoff;
  logic [23:0] den1_prod;
  logic [8:0]  den1;

  always_comb begin
    expert     = tilt_mode == MODE_EXPERT;
    effect_off = tilt_effect >= EXPERT_EFFECT_MAX;
    cut_span   = EXPERT_EFFECT_MAX - tilt_effect;
    cutoff     = 12'(cut_span) * 12'd18;
    den1_prod  = 24'(cutoff) * 24'(DIV10_RECIP);
    den1       = den1_prod[23:15];
  end

  logic [N_STAGES-1:0] v;
  logic [N_STAGES-1:0] adv;

  always_comb begin
    adv[N_STAGES-1] = !v[N_STAGES-1] || result.ready;
    for (int k = N_STAGES - 2; k >= 0; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= sample.valid;
      end
      for (int k = 1; k < N_STAGES; k++) begin
        if (adv[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign sample.ready = adv[0];
  assign result.valid = v[N_STAGES-1];

  // stage 0: base strength complement and tilt
  logic [ANGLE_W-1:0] roll_bits;
  logic [ANGLE_W-1:0] pitch_bits;
  logic [ANGLE_W-1:0] roll_abs;
  logic [ANGLE_W-1:0] pitch_abs;
  logic [ANGLE_W-1:0] tilt_in;
  logic               defl_over;
  logic [DEFL_W-1:0]  defl_span;
  logic [16:0]        defl_prod;
  logic [6:0]         defl_q;
  logic [6:0]         m0_in;

  always_comb begin
    roll_bits  = sample.roll_angle;
    pitch_bits = sample.pitch_angle;
    roll_abs   = roll_bits[ANGLE_W-1] ? (~roll_bits + ANGLE_W'(1)) : roll_bits;
    pitch_abs  = pitch_bits[ANGLE_W-1] ? (~pitch_bits + ANGLE_W'(1)) : pitch_bits;
    tilt_in    = (roll_abs > pitch_abs) ? roll_abs : pitch_abs;
    defl_over  = sample.stick_deflection > DEFL_FULL;
    defl_span  = defl_over ? (sample.stick_deflection - DEFL_FULL)
                           : (DEFL_FULL - sample.stick_deflection);
    defl_prod  = 17'(defl_span) * 17'(DIV5_RECIP);
    defl_q     = defl_prod[16:10];
    m0_in      = defl_over ? (STRENGTH_MAX + defl_q) : (STRENGTH_MAX - defl_q);
  end

  logic [6:0]         st0_m0;
  logic [ANGLE_W-1:0] st0_tilt;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      st0_m0   <= m0_in;
      st0_tilt <= tilt_in;
    end
  end

  // stage 1: numerators and tilt term
  logic signed [12:0] tilt_ext;
  logic signed [12:0] cut_diff;
  logic signed [12:0] safe_diff;
  logic [10:0]        safe_mag;
  logic [22:0]        safe_prod;
  logic [6:0]         safe_q;
  logic signed [7:0]  q18_calc;
  hls_carry_t         carry1_in;

  always_comb begin
    tilt_ext           = $signed({1'b0, st0_tilt});
    cut_diff           = $signed({1'b0, cutoff}) - tilt_ext;
    safe_diff          = 13'sd1800 - tilt_ext;
    safe_mag           = safe_diff[12] ? 11'(-safe_diff) : safe_diff[10:0];
    safe_prod          = 23'(safe_mag) * 23'(DIV18_RECIP);
    safe_q             = safe_prod[22:16];
    q18_calc           = safe_diff[12] ? -$signed({1'b0, safe_q}) : $signed({1'b0, safe_q});
    carry1_in.m        = 14'(st0_m0) * 14'd100;
    carry1_in.num1_neg = cut_diff[12];
    carry1_in.num1     = cut_diff[12] ? '0 : 15'(cut_diff[11:0]) * 15'd10;
  end

  hls_carry_t        st1_carry;
  logic signed [7:0] st1_q18;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      st1_carry <= carry1_in;
      st1_q18   <= q18_calc;
    end
  end

  // stage 2: tilt term times effect
  logic signed [16:0] t_calc;

  assign t_calc = st1_q18 * $signed({1'b0, tilt_effect});

  hls_carry_t         st2_carry;
  logic signed [15:0] st2_t;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      st2_carry <= st1_carry;
      st2_t     <= t_calc[15:0];
    end
  end

  // stage 3: safe inclination ratio
  logic               t_neg;
  logic [15:0]        t_mag;
  logic [10:0]        t_div;
  logic signed [10:0] t_signed;
  logic signed [10:0] ratio_calc;

  always_comb begin
    t_neg      = st2_t[15];
    t_mag      = t_neg ? 16'(-st2_t) : st2_t;
    t_div      = div100({1'b0, t_mag});
    t_signed   = t_neg ? -$signed(t_div) : $signed(t_div);
    ratio_calc = t_signed + 11'sd100 - $signed({3'b0, tilt_effect});
  end

  hls_carry_t        st3_carry;
  logic signed [9:0] st3_ratio;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      st3_carry <= st2_carry;
      st3_ratio <= ratio_calc[9:0];
    end
  end

  // stage 4: sensitivity times ratio
  logic signed [18:0] p_calc;

  assign p_calc = $signed({1'b0, level_sensitivity}) * st3_ratio;

  hls_carry_t         st4_carry;
  logic signed [17:0] st4_p;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      st4_carry <= st3_carry;
      st4_p     <= p_calc[17:0];
    end
  end

  // stage 5: divisor selection
  logic                 p_neg;
  logic [16:0]          p_mag;
  logic [10:0]          fact_div;
  logic [9:0]           fact;
  logic [DIV_DEN_W-1:0] a_den_in;
  hls_side_t            side_in;

  always_comb begin
    p_neg    = st4_p[17];
    p_mag    = p_neg ? 17'(-st4_p) : st4_p[16:0];
    fact_div = div100(p_mag);
    if (tilt_effect == '0) begin
      fact = {2'b0, level_sensitivity};
    end else if (p_neg) begin
      fact = '0;
    end else begin
      fact = fact_div[9:0];
    end
    a_den_in         = expert ? {2'b0, level_sensitivity} : fact;
    side_in.expert   = expert;
    side_in.num1_neg = st4_carry.num1_neg;
    side_in.zero     = expert ? (effect_off || level_sensitivity == '0) : (fact == '0);
  end

  logic [DIV_NUM_W-1:0] st5_a_num;
  logic [DIV_DEN_W-1:0] st5_a_den;
  logic [DIV_NUM_W-1:0] st5_b_num;
  logic [DIV_DEN_W-1:0] st5_b_den;
  hls_side_t            st5_side;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      st5_a_num <= {1'b0, st4_carry.m};
      st5_a_den <= a_den_in;
      st5_b_num <= st4_carry.num1;
      st5_b_den <= {1'b0, den1};
      st5_side  <= side_in;
    end
  end

  // stages 6..13: strength and inclination divisions
  logic [DIV_Q_W-1:0] qa;
  logic [DIV_Q_W-1:0] qb;
  hls_side_t          side [DIV_STAGES];

  hls_div u_div_strength (
    .clk  (clk),
    .adv  (adv[ST_DIV0 +: DIV_STAGES]),
    .num  (st5_a_num),
    .den  (st5_a_den),
    .quot (qa)
  );

  hls_div u_div_incl (
    .clk  (clk),
    .adv  (adv[ST_DIV0 +: DIV_STAGES]),
    .num  (st5_b_num),
    .den  (st5_b_den),
    .quot (qb)
  );

  always_ff @(posedge clk) begin
    if (adv[ST_DIV0]) begin
      side[0] <= st5_side;
    end
    for (int j = 1; j < DIV_STAGES; j++) begin
      if (adv[ST_DIV0+j]) begin
        side[j] <= side[j-1];
      end
    end
  end

  // stage 14: strength times ratio
  hls_side_t   side_last;
  logic [6:0]  strength1;
  logic [6:0]  ratio_fin;
  logic [13:0] prod_calc;

  always_comb begin
    side_last = side[DIV_STAGES-1];
    strength1 = (side_last.zero || qa >= STRENGTH_MAX) ? '0 : (STRENGTH_MAX - qa);
    if (!side_last.expert) begin
      ratio_fin = STRENGTH_MAX;
    end else if (side_last.num1_neg) begin
      ratio_fin = '0;
    end else begin
      ratio_fin = (qb >= STRENGTH_MAX) ? STRENGTH_MAX : qb;
    end
    prod_calc = 14'(strength1) * 14'(ratio_fin);
  end

  logic [13:0] st14_prod;

  always_ff @(posedge clk) begin
    if (adv[ST_PROD]) begin
      st14_prod <= prod_calc;
    end
  end

  // stage 15: scale back to percent
  logic [10:0] out_div;
  strength_t   st15_level;

  assign out_div = div100({3'b0, st14_prod});

  always_ff @(posedge clk) begin
    if (adv[ST_OUT]) begin
      st15_level <= out_div[STRENGTH_W-1:0];
    end
  end

  assign result.level_strength = st15_level;

  `HLS_ASSERT_IMPL(a_level_range, clk, rst, result.valid, result.level_strength <= STRENGTH_MAX, "level strength above full scale")
  `HLS_ASSERT_IMPL(a_stall_full, clk, rst, !sample.ready, &v, "input held off with a free stage")
  `HLS_ASSERT_NEXT(a_accept_fill, clk, rst, sample.valid && sample.ready, v[0], "accepted item not captured")

endmodule

`default_nettype wire

### tb/horizon_level_strength_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Horizon leveling strength testbench
// Drives samples through the valid/ready input channel under a series of
// tilt settings in safe and expert mode, predicts each leveling strength in
// a scoreboard and compares every result in order. Both channels idle in
// random bursts; one phase holds off the result side to back up the pipeline.
// ----------------------------------------------------------------------------

module horizon_level_strength_tb;
  import hls_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 60;
  localparam int NUM_PHASES  = 10;
  localparam int DRAIN_WAIT  = 24;
  localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_SPARE = 2'd3;

  class strength_scoreboard;
    logic      mode;
    int        effect;
    int        sens;
    strength_t expected_q[$];
    int        errors;
    int        checked;

    function new();
      mode    = MODE_SAFE;
      effect  = int'(TILT_EFFECT_RESET);
      sens    = int'(LEVEL_SENS_RESET);
      errors  = 0;
      checked = 0;
    endfunction

    function void set_config(logic m, logic [7:0] e, logic [7:0] s);
      mode   = m;
      effect = int'(e);
      sens   = int'(s);
    endfunction

    function int clamp_pct(int x);
      if (x < 0) return 0;
      if (x > 100) return 100;
      return x;
    endfunction

    function strength_t predict_strength(defl_t d, angle_t r, angle_t p);
      int roll_abs, pitch_abs, tilt, strength, cutoff, ratio, base, fact;
      roll_abs  = int'(r);
      pitch_abs = int'(p);
      if (roll_abs < 0) roll_abs = -roll_abs;
      if (pitch_abs < 0) pitch_abs = -pitch_abs;
      tilt = (roll_abs > pitch_abs) ? roll_abs : pitch_abs;
      strength = (500 - int'(d)) / 5;
      if (mode == MODE_EXPERT) begin
        if (effect < 175) begin
          cutoff = (175 - effect) * 18;
          ratio = clamp_pct(((cutoff - tilt) * 10) / (cutoff / 10));
          if (sens <= 0) strength = 0;
          else strength = (strength - 100) * 100 / sens + 100;
          strength = strength * ratio / 100;
        end else begin
          strength = 0;
        end
      end else begin
        if (effect > 0) begin
          base = 100 - effect;
          ratio = ((1800 - tilt) / 18 * (100 - base)) / 100 + base;
          fact = sens * ratio / 100;
        end else begin
          fact = sens;
        end
        if (fact <= 0) strength = 0;
        else strength = (strength - 100) * 100 / fact + 100;
      end
      return strength_t'(clamp_pct(strength));
    endfunction

    function void note_sample(defl_t d, angle_t r, angle_t p);
      expected_q.push_back(predict_strength(d, r, p));
    endfunction

    function void check_result(strength_t got);
      strength_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected level_strength: expected none, actual %0d", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got !== want) begin
        $display("%0t: level_strength mismatch: expected %0d, actual %0d", $time, want, got);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  hls_sample_if   sample_ch();
  hls_strength_if result_ch();

  horizon_level_strength dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch.sink),
    .result    (result_ch.source)
  );

  strength_scoreboard sb = new();
  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;
  int cycles   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("horizon_level_strength regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (sample_ch.valid && sample_ch.ready)
        sb.note_sample(sample_ch.stick_deflection, sample_ch.roll_angle,
                       sample_ch.pitch_angle);
      if (result_ch.valid && result_ch.ready)
        sb.check_result(result_ch.level_strength);
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic apply_settings(input logic m, input logic [7:0] e, input logic [7:0] s);
    cfg_write <= 1'b1;
    cfg_index <= CFG_TILT_MODE;
    cfg_data  <= {7'd0, m};
    @(posedge clk);
    cfg_index <= CFG_TILT_EFFECT;
    cfg_data  <= e;
    @(posedge clk);
    cfg_index <= CFG_LEVEL_SENS;
    cfg_data  <= s;
    @(posedge clk);
    cfg_index <= CFG_INDEX_SPARE;
    cfg_data  <= 8'($urandom);
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_config(m, e, s);
  endtask

  task automatic send_sample(input defl_t d, input angle_t r, input angle_t p);
    sample_ch.valid            <= 1'b1;
    sample_ch.stick_deflection <= d;
    sample_ch.roll_angle       <= r;
    sample_ch.pitch_angle      <= p;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic drain();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic angle_t random_angle();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return angle_t'(int'($urandom_range(0, 3600)) - 1800);
    if (pick < 8) return angle_t'($urandom);
    return angle_t'(int'($urandom_range(0, 40)) - 20);
  endfunction

  task automatic random_sample();
    defl_t d;
    int    pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) d = defl_t'($urandom_range(0, 500));
    else if (pick < 9) d = defl_t'($urandom_range(501, 511));
    else d = defl_t'($urandom);
    send_sample(d, random_angle(), random_angle());
  endtask

  task automatic directed_samples();
    send_sample(9'd0, 12'sd0, 12'sd0);
    send_sample(9'd500, 12'sd0, 12'sd0);
    send_sample(9'd511, 12'sd0, 12'sd0);
    send_sample(9'd250, 12'sd900, -12'sd900);
    send_sample(9'd100, 12'sd1800, 12'sd0);
    send_sample(9'd100, 12'sd0, -12'sd1800);
    send_sample(9'd0, 12'sd2047, 12'sd0);
    send_sample(9'd0, -12'sd2048, 12'sd5);
    send_sample(9'd499, -12'sd1, 12'sd1);
    send_sample(9'd1, 12'sd1799, -12'sd1799);
    send_sample(9'd300, -12'sd2048, -12'sd2048);
    send_sample(9'd5, 12'sd600, 12'sd1200);
  endtask

  logic       phase_mode[NUM_PHASES]   = '{1, 1, 1, 1, 0, 0, 0, 0, 1, 0};
  logic [7:0] phase_effect[NUM_PHASES] = '{0, 174, 175, 100, 0, 250, 101, 255, 255, 0};
  logic [7:0] phase_sens[NUM_PHASES]   = '{255, 1, 100, 0, 255, 1, 0, 200, 75, 0};

  initial begin
    int n;
    rst                        <= 1'b1;
    cfg_write                  <= 1'b0;
    cfg_index                  <= CFG_TILT_MODE;
    cfg_data                   <= '0;
    sample_ch.valid            <= 1'b0;
    sample_ch.stick_deflection <= '0;
    sample_ch.roll_angle       <= '0;
    sample_ch.pitch_angle      <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_samples();
    drain();
    apply_settings(MODE_EXPERT, 8'd75, 8'd75);
    directed_samples();
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == NUM_PHASES - 1) begin
        idle_on = 1'b0;
        apply_settings(1'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        apply_settings(phase_mode[ph], phase_effect[ph], phase_sens[ph]);
      end
      n = PHASE_ITEMS;
      if (ph == 1) begin
        hold_req = 1'b1;
        n = PHASE_ITEMS + 20;
      end
      repeat (n) random_sample();
      drain();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    $display("checked %0d strength results over %0d tilt settings", sb.checked,
             NUM_PHASES + 2);
    $display("safe and expert modes, register extremes, stick and angle extremes");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("horizon_level_strength regression: pass");
    end else begin
      $display("horizon_level_strength regression: fail");
    end
    $finish;
  end

endmodule
